@@ hw/rtl/shifting_sequence_list_assert.svh @@
// Assertion macros for the shifting sequence list
`ifndef SHIFTING_SEQUENCE_LIST_ASSERT_SVH
`define SHIFTING_SEQUENCE_LIST_ASSERT_SVH

// same-cycle implication, reset masked
`define SSL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ssl_pkg.sv @@
`timescale 1ns / 1ps

package ssl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int WORD_WIDTH = 32;

  typedef enum logic [2:0] {
    CMD_TAIL_ADD  = 3'd0,
    CMD_TAIL_DROP = 3'd1,
    CMD_HEAD_ADD  = 3'd2,
    CMD_HEAD_DROP = 3'd3,
    CMD_INSERT    = 3'd4,
    CMD_ERASE     = 3'd5,
    CMD_FIND      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // per-cell controls for one cycle
  typedef struct packed {
    logic load;     // take the request value
    logic from_lo;  // take the entry of the cell below
    logic from_hi;  // take the entry of the cell above
    logic held;     // position lies below the count
  } cell_ctl_t;

endpackage

@@ hw/rtl/ssl_cell.sv @@
`timescale 1ns / 1ps

module ssl_cell #(
  parameter int DATA_WIDTH = ssl_pkg::WORD_WIDTH
) (
  input  logic                  clk,
  input  ssl_pkg::cell_ctl_t    ctl,
  input  logic [DATA_WIDTH-1:0] lo_data,
  input  logic [DATA_WIDTH-1:0] hi_data,
  input  logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = value;
    end else if (ctl.from_lo) begin
      entry_nxt = lo_data;
    end else if (ctl.from_hi) begin
      entry_nxt = hi_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = ctl.held && (entry_r == value);

endmodule

@@ hw/rtl/shifting_sequence_list.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake         | Payload
// in_      | input     | in_valid/in_stall | in_cmd, in_position, in_value
// out_     | output    | out_valid/out_stall | out_status, out_found, out_count
//
// One request per cycle while in_stall is low; the result is registered.
// The rate is set by the row of cells, which shifts and compares all entries in parallel.
// Reset clears the count and output valids only; entries need no clearing pass.
// Results sit in an output register plus one skid stage; in_stall rises while the skid
// stage holds a result.

module shifting_sequence_list #(
  parameter int DEPTH      = ssl_pkg::LIST_DEPTH,
  parameter int DATA_WIDTH = ssl_pkg::WORD_WIDTH,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_cmd,
  input  logic [CNT_W-1:0]      in_position,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic                  out_found,
  output logic [CNT_W-1:0]      out_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic                  acc;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [CNT_W-1:0]      at;
  logic                  do_ins;
  logic                  do_era;
  logic                  fnd_nxt;
  ssl_pkg::status_t      st_nxt;
  logic                  full;
  logic                  empty;

  ssl_pkg::cell_ctl_t    ctl [DEPTH];
  logic [DATA_WIDTH-1:0] ent [DEPTH];
  logic [DEPTH-1:0]      match;

  logic                  out_valid_r;
  ssl_pkg::status_t      out_status_r;
  logic                  out_found_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  sk_valid_r;
  ssl_pkg::status_t      sk_status_r;
  logic                  sk_found_r;
  logic [CNT_W-1:0]      sk_count_r;
  logic                  pop;

  assign in_stall = sk_valid_r;
  assign acc      = in_valid && !sk_valid_r;
  assign pop      = out_valid_r && !out_stall;
  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);

  always_comb begin
    st_nxt  = ssl_pkg::ST_OK;
    fnd_nxt = 1'b0;
    do_ins  = 1'b0;
    do_era  = 1'b0;
    at      = '0;
    cnt_nxt = cnt_r;
    case (ssl_pkg::cmd_t'(in_cmd))
      ssl_pkg::CMD_TAIL_ADD: begin
        if (full) begin
          st_nxt = ssl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          at     = cnt_r;
        end
      end
      ssl_pkg::CMD_TAIL_DROP: begin
        if (empty) begin
          st_nxt = ssl_pkg::ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ssl_pkg::CMD_HEAD_ADD: begin
        if (full) begin
          st_nxt = ssl_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      ssl_pkg::CMD_HEAD_DROP: begin
        if (empty) begin
          st_nxt = ssl_pkg::ST_EMPTY;
        end else begin
          do_era = 1'b1;
        end
      end
      ssl_pkg::CMD_INSERT: begin
        if (full) begin
          st_nxt = ssl_pkg::ST_FULL;
        end else if (in_position > cnt_r) begin
          st_nxt = ssl_pkg::ST_BADPOS;
        end else begin
          do_ins = 1'b1;
          at     = in_position;
        end
      end
      ssl_pkg::CMD_ERASE: begin
        if (empty) begin
          st_nxt = ssl_pkg::ST_EMPTY;
        end else if (in_position >= cnt_r) begin
          st_nxt = ssl_pkg::ST_BADPOS;
        end else begin
          do_era = 1'b1;
          at     = in_position;
        end
      end
      ssl_pkg::CMD_FIND: begin
        fnd_nxt = |match;
      end
      default: begin
      end
    endcase
    if (do_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_era) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
    localparam logic [CNT_W-1:0] IDX1 = CNT_W'(i + 1);
    logic [DATA_WIDTH-1:0] lo_d;
    logic [DATA_WIDTH-1:0] hi_d;

    assign ctl[i].load    = acc && do_ins && (at == IDX);
    assign ctl[i].from_lo = acc && do_ins && (IDX > at) && (IDX <= cnt_r);
    assign ctl[i].from_hi = acc && do_era && (IDX >= at) && (IDX1 < cnt_r);
    assign ctl[i].held    = (IDX < cnt_r);

    if (i == 0) begin : g_lo_edge
      assign lo_d = in_value;
    end else begin : g_lo
      assign lo_d = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_edge
      assign hi_d = in_value;
    end else begin : g_hi
      assign hi_d = ent[i+1];
    end

    ssl_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl[i]),
      .lo_data(lo_d),
      .hi_data(hi_d),
      .value  (in_value),
      .entry  (ent[i]),
      .match  (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r <= cnt_nxt;
      end
      if (sk_valid_r) begin
        if (pop) begin
          out_status_r <= sk_status_r;
          out_found_r  <= sk_found_r;
          out_count_r  <= sk_count_r;
          sk_valid_r   <= 1'b0;
        end
      end else if (acc) begin
        if (!out_valid_r || pop) begin
          out_status_r <= st_nxt;
          out_found_r  <= fnd_nxt;
          out_count_r  <= cnt_nxt;
          out_valid_r  <= 1'b1;
        end else begin
          sk_status_r <= st_nxt;
          sk_found_r  <= fnd_nxt;
          sk_count_r  <= cnt_nxt;
          sk_valid_r  <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

`include "shifting_sequence_list_assert.svh"

  `SSL_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= FULL_CNT, "count above depth")
  `SSL_ASSERT_IMPL(a_skid_order, sk_valid_r, out_valid_r, "skid holds result ahead of output")
  `SSL_ASSERT_NEXT(a_refused_hold, acc && (st_nxt != ssl_pkg::ST_OK), cnt_r == $past(cnt_r),
                   "refused request changed count")
  `SSL_ASSERT_IMPL(a_found_ok, out_valid_r && out_found_r, out_status_r == ssl_pkg::ST_OK,
                   "found flagged with error status")

endmodule

@@ tb/sv/tb_shifting_sequence_list.sv @@
`timescale 1ns / 1ps

module tb_shifting_sequence_list;

  localparam int LIST_DEPTH = ssl_pkg::LIST_DEPTH;
  localparam int WORD_WIDTH = ssl_pkg::WORD_WIDTH;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam logic [2:0] CMD_SPARE = 3'd7;
  localparam int HOLD_LEN = 60;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 10;
  localparam int RANDOM_PER_PHASE = 360;

  typedef struct {
    logic [2:0]            op;
    logic [CNT_W-1:0]      pos;
    logic [WORD_WIDTH-1:0] word;
  } list_cmd_t;

  typedef struct {
    ssl_pkg::status_t status;
    logic             found;
    logic [CNT_W-1:0] count;
  } list_reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_cmd = '0;
  logic [CNT_W-1:0]      in_position = '0;
  logic [WORD_WIDTH-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic                  out_found;
  logic [CNT_W-1:0]      out_count;

  list_cmd_t   cmd_backlog[$];
  list_reply_t list_replies_due[$];

  // shadow of the list contents
  logic [WORD_WIDTH-1:0] model_words[LIST_DEPTH];
  int                    model_len = 0;

  // request generator state: count only, plus recent words for find hits
  int                    gen_len = 0;
  bit                    filling = 1'b1;
  logic [WORD_WIDTH-1:0] word_pool[8];
  int                    pool_wr = 0;

  int tx_idle_pct = 30;
  int rx_idle_pct = 84;
  bit rx_hold_req = 1'b0;
  int rx_hold_count = 0;
  int quiet_cycles = 0;
  int fault_count = 0;
  int requests_taken = 0;
  int cmd_seen[8];
  int status_seen[4];
  int find_hits = 0;

  shifting_sequence_list dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_cmd      (in_cmd),
    .in_position (in_position),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_found   (out_found),
    .out_count   (out_count)
  );

  always #1 clk = ~clk;

  function automatic void open_slot(int at);
    int k;
    for (k = model_len; k > at; k--) model_words[k] = model_words[k-1];
  endfunction

  function automatic void close_slot(int at);
    int k;
    for (k = at; k + 1 < model_len; k++) model_words[k] = model_words[k+1];
  endfunction

  function automatic list_reply_t apply_list_command(logic [2:0] op, logic [CNT_W-1:0] pos,
                                                     logic [WORD_WIDTH-1:0] word);
    list_reply_t r;
    int k;
    r.status = ssl_pkg::ST_OK;
    r.found  = 1'b0;
    case (op)
      ssl_pkg::CMD_TAIL_ADD: begin
        if (model_len >= LIST_DEPTH) r.status = ssl_pkg::ST_FULL;
        else begin
          model_words[model_len] = word;
          model_len++;
        end
      end
      ssl_pkg::CMD_TAIL_DROP: begin
        if (model_len == 0) r.status = ssl_pkg::ST_EMPTY;
        else model_len--;
      end
      ssl_pkg::CMD_HEAD_ADD: begin
        if (model_len >= LIST_DEPTH) r.status = ssl_pkg::ST_FULL;
        else begin
          open_slot(0);
          model_words[0] = word;
          model_len++;
        end
      end
      ssl_pkg::CMD_HEAD_DROP: begin
        if (model_len == 0) r.status = ssl_pkg::ST_EMPTY;
        else begin
          close_slot(0);
          model_len--;
        end
      end
      ssl_pkg::CMD_INSERT: begin
        if (model_len >= LIST_DEPTH) r.status = ssl_pkg::ST_FULL;
        else if (int'(pos) > model_len) r.status = ssl_pkg::ST_BADPOS;
        else begin
          open_slot(int'(pos));
          model_words[int'(pos)] = word;
          model_len++;
        end
      end
      ssl_pkg::CMD_ERASE: begin
        if (model_len == 0) r.status = ssl_pkg::ST_EMPTY;
        else if (int'(pos) >= model_len) r.status = ssl_pkg::ST_BADPOS;
        else begin
          close_slot(int'(pos));
          model_len--;
        end
      end
      ssl_pkg::CMD_FIND: begin
        for (k = 0; k < model_len; k++) if (model_words[k] == word) r.found = 1'b1;
      end
      default: ;
    endcase
    r.count = model_len[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [WORD_WIDTH-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4, 5: return word_pool[3'($urandom_range(7))];
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_cmd(logic [2:0] op, logic [CNT_W-1:0] pos, logic [WORD_WIDTH-1:0] word);
    list_cmd_t c;
    c.op   = op;
    c.pos  = pos;
    c.word = word;
    cmd_backlog.insert(cmd_backlog.size(), c);
    case (op)
      ssl_pkg::CMD_TAIL_ADD, ssl_pkg::CMD_HEAD_ADD, ssl_pkg::CMD_INSERT: begin
        word_pool[pool_wr] = word;
        pool_wr = (pool_wr + 1) % 8;
        if (gen_len < LIST_DEPTH && (op != ssl_pkg::CMD_INSERT || int'(pos) <= gen_len))
          gen_len++;
      end
      ssl_pkg::CMD_TAIL_DROP, ssl_pkg::CMD_HEAD_DROP: if (gen_len > 0) gen_len--;
      ssl_pkg::CMD_ERASE: if (gen_len > 0 && int'(pos) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // mostly fill/drain sweeps between empty and full, some noise
  task automatic queue_random(int n);
    int i;
    int r;
    logic [2:0] op;
    logic [CNT_W-1:0] pos;
    for (i = 0; i < n; i++) begin
      if (filling && gen_len == LIST_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      else if (!filling && gen_len == 0 && $urandom_range(3) == 0) filling = 1'b1;
      else if ($urandom_range(49) == 0) filling = !filling;
      r = $urandom_range(99);
      pos = CNT_W'($urandom_range(31));
      if (r < 8) op = 3'($urandom_range(7));
      else if (r < 25) op = ssl_pkg::CMD_FIND;
      else if (filling) begin
        case ($urandom_range(2))
          0: op = ssl_pkg::CMD_TAIL_ADD;
          1: op = ssl_pkg::CMD_HEAD_ADD;
          default: op = ssl_pkg::CMD_INSERT;
        endcase
      end else begin
        case ($urandom_range(2))
          0: op = ssl_pkg::CMD_TAIL_DROP;
          1: op = ssl_pkg::CMD_HEAD_DROP;
          default: op = ssl_pkg::CMD_ERASE;
        endcase
      end
      if (r >= 8 && $urandom_range(9) != 0) begin
        if (op == ssl_pkg::CMD_INSERT) pos = CNT_W'($urandom_range(gen_len));
        else if (op == ssl_pkg::CMD_ERASE && gen_len > 0)
          pos = CNT_W'($urandom_range(gen_len - 1));
      end
      queue_cmd(op, pos, pick_word());
    end
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || in_valid || list_replies_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  always @(posedge clk) begin : request_driver
    logic offer;
    list_cmd_t nxt;
    list_reply_t rep;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && !in_stall) begin
        rep = apply_list_command(in_cmd, in_position, in_value);
        list_replies_due.insert(list_replies_due.size(), rep);
        cmd_seen[in_cmd]++;
        requests_taken++;
        offer = 1'b0;
      end
      if (!offer && cmd_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = cmd_backlog[0];
        cmd_backlog.delete(0);
        in_cmd      <= nxt.op;
        in_position <= nxt.pos;
        in_value    <= nxt.word;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin : result_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold_req && rx_hold_count < HOLD_LEN) begin
      out_stall <= 1'b1;
      rx_hold_count <= rx_hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    list_reply_t due;
    if (rst_n && out_valid && !out_stall) begin
      status_seen[out_status]++;
      if (out_found) find_hits++;
      if (list_replies_due.size() == 0) begin
        report_fault($sformatf("unexpected result status=%0d found=%0d count=%0d",
                               out_status, out_found, out_count));
      end else begin
        due = list_replies_due[0];
        list_replies_due.delete(0);
        if (out_status !== due.status || out_found !== due.found || out_count !== due.count)
          report_fault($sformatf("status %0d/%0d found %0d/%0d count %0d/%0d (exp/act)",
                                 due.status, out_status, due.found, out_found,
                                 due.count, out_count));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < 8; i++) word_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty-list refusals, then a bad insert position
    queue_cmd(ssl_pkg::CMD_TAIL_DROP, '0, '0);
    queue_cmd(ssl_pkg::CMD_HEAD_DROP, '0, '0);
    queue_cmd(ssl_pkg::CMD_ERASE, 5'd31, '0);
    queue_cmd(ssl_pkg::CMD_FIND, '0, '0);
    queue_cmd(ssl_pkg::CMD_INSERT, 5'd1, 32'h1234_5678);
    queue_cmd(ssl_pkg::CMD_INSERT, '0, 32'h8000_0000);
    queue_cmd(ssl_pkg::CMD_TAIL_ADD, '0, 32'h7fff_ffff);
    queue_cmd(ssl_pkg::CMD_HEAD_ADD, '0, 32'hffff_ffff);
    queue_cmd(ssl_pkg::CMD_FIND, '0, 32'h8000_0000);
    queue_cmd(ssl_pkg::CMD_ERASE, 5'd3, '0);
    queue_cmd(CMD_SPARE, 5'd31, 32'hffff_ffff);
    queue_cmd(ssl_pkg::CMD_INSERT, 5'd3, '0);
    for (i = 0; i < 12; i++) queue_cmd(ssl_pkg::CMD_TAIL_ADD, '0, $urandom);
    // full list: refusal comes before the position check
    queue_cmd(ssl_pkg::CMD_TAIL_ADD, '0, '1);
    queue_cmd(ssl_pkg::CMD_INSERT, 5'd31, '1);
    queue_cmd(ssl_pkg::CMD_HEAD_ADD, '0, '1);
    queue_cmd(ssl_pkg::CMD_ERASE, 5'd15, '0);
    queue_cmd(ssl_pkg::CMD_FIND, '0, 32'hffff_ffff);
    wait_drained();

    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    tx_idle_pct = 84;
    rx_idle_pct = 30;
    queue_random(RANDOM_PER_PHASE);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    @(posedge clk);
    rx_hold_req <= 1'b1;
    while (rx_hold_count < HOLD_LEN) @(posedge clk);
    rx_hold_req <= 1'b0;
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Requests taken %0d: add tail %0d drop tail %0d add head %0d drop head %0d",
             requests_taken, cmd_seen[ssl_pkg::CMD_TAIL_ADD],
             cmd_seen[ssl_pkg::CMD_TAIL_DROP], cmd_seen[ssl_pkg::CMD_HEAD_ADD],
             cmd_seen[ssl_pkg::CMD_HEAD_DROP]);
    $display("insert %0d erase %0d find %0d (hits %0d) spare %0d; %s %0d %0d %0d %0d",
             cmd_seen[ssl_pkg::CMD_INSERT], cmd_seen[ssl_pkg::CMD_ERASE],
             cmd_seen[ssl_pkg::CMD_FIND], find_hits, cmd_seen[CMD_SPARE],
             "ok/full/empty/badpos", status_seen[ssl_pkg::ST_OK],
             status_seen[ssl_pkg::ST_FULL], status_seen[ssl_pkg::ST_EMPTY],
             status_seen[ssl_pkg::ST_BADPOS]);
    if (fault_count == 0 && list_replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fault_count, list_replies_due.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ssl_pkg.sv
hw/rtl/ssl_cell.sv
hw/rtl/shifting_sequence_list.sv
tb/sv/tb_shifting_sequence_list.sv
